// ===== rtl/soft_circular_alpha_brush_top_macros.svh =====
// Assertion macros for the soft circular alpha brush.
// Used by soft_circular_alpha_brush_top; depends on nothing.
`ifndef SOFT_CIRCULAR_ALPHA_BRUSH_TOP_MACROS_SVH
`define SOFT_CIRCULAR_ALPHA_BRUSH_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SCAB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SCAB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/scab_pkg.sv =====
// Shared constants and types of the soft circular alpha brush.
// No dependencies; imported by every module of the block.
package scab_pkg;

   localparam int COORD_BITS_DEF     = 12;
   localparam int DIST_FRAC_BITS_DEF = 4;

   localparam int RAD_BITS      = 12;
   localparam int ALPHA_BITS    = 8;
   localparam int HARD_BITS     = 9;
   localparam int STR_FRAC_BITS = 8;
   localparam int STR_BITS      = STR_FRAC_BITS + 1;
   localparam int HALF_LSB      = 128;

   localparam logic [STR_BITS-1:0]   STR_ONE   = 9'd256;
   localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = 8'hFF;

   localparam int CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_COL   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_ROW   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BRUSH_RADIUS = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TARGET_ALPHA = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HARDNESS_Q8  = 3'd4;

   // Side data that rides along with a pixel through the cell chains
   typedef struct packed {
      logic [ALPHA_BITS-1:0] cur;
      logic                  hit;
      logic                  full;
   } pass_type;

endpackage

// ===== rtl/scab_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root: one result bit per cell.
// Depends on scab_pkg.
module scab_sqrt_cell #(
   parameter int ROOT_BITS = scab_pkg::RAD_BITS + scab_pkg::DIST_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic [ROOT_BITS+1:0]     up_rem,
   input  logic [ROOT_BITS-1:0]     up_root,
   input  logic [2*ROOT_BITS-1:0]   up_arg,
   input  scab_pkg::pass_type       up_pass,
   output logic [ROOT_BITS+1:0]     dn_rem,
   output logic [ROOT_BITS-1:0]     dn_root,
   output logic [2*ROOT_BITS-1:0]   dn_arg,
   output scab_pkg::pass_type       dn_pass
);
   import scab_pkg::*;

   localparam int RW = ROOT_BITS + 2;
   localparam int AB = 2 * ROOT_BITS;

   logic [RW-1:0]        pull;
   logic [RW-1:0]        trial;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [AB-1:0]        arg_ff, arg_in;
   pass_type             pass_ff;

   always_comb begin
      // bring down the next two argument bits
      pull   = {up_rem[RW-3:0], up_arg[AB-1 -: 2]};
      trial  = {up_root, 2'b01};
      arg_in = {up_arg[AB-3:0], 2'b00};
      if (pull >= trial) begin
         rem_in  = pull - trial;
         root_in = {up_root[ROOT_BITS-2:0], 1'b1};
      end else begin
         rem_in  = pull;
         root_in = {up_root[ROOT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         arg_ff  <= arg_in;
         pass_ff <= up_pass;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_arg  = arg_ff;
   assign dn_pass = pass_ff;

endmodule

// ===== rtl/scab_div_cell.sv =====
// One restoring-division cell: one quotient bit of the falloff strength per cell.
// Depends on scab_pkg.
module scab_div_cell #(
   parameter int NUM_BITS = scab_pkg::RAD_BITS + scab_pkg::DIST_FRAC_BITS_DEF
                            + scab_pkg::STR_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              advance,
   input  logic [NUM_BITS-1:0]               divisor,
   input  logic [NUM_BITS-1:0]               up_rem,
   input  logic [scab_pkg::STR_FRAC_BITS-1:0] up_quo,
   input  scab_pkg::pass_type                up_pass,
   output logic [NUM_BITS-1:0]               dn_rem,
   output logic [scab_pkg::STR_FRAC_BITS-1:0] dn_quo,
   output scab_pkg::pass_type                dn_pass
);
   import scab_pkg::*;

   logic [NUM_BITS:0]          shifted;
   logic [NUM_BITS:0]          diff;
   logic [NUM_BITS-1:0]        rem_ff, rem_in;
   logic [STR_FRAC_BITS-1:0]   quo_ff, quo_in;
   pass_type                   pass_ff;

   always_comb begin
      shifted = {up_rem, 1'b0};
      diff    = shifted - {1'b0, divisor};
      if (shifted >= {1'b0, divisor}) begin
         rem_in = diff[NUM_BITS-1:0];
         quo_in = {up_quo[STR_FRAC_BITS-2:0], 1'b1};
      end else begin
         rem_in = shifted[NUM_BITS-1:0];
         quo_in = {up_quo[STR_FRAC_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         pass_ff <= up_pass;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_quo  = quo_ff;
   assign dn_pass = pass_ff;

endmodule

// ===== rtl/soft_circular_alpha_brush_top.sv =====
// Top level of the soft circular alpha brush: distance, falloff and blend pipeline.
// Depends on scab_pkg, scab_sqrt_cell, scab_div_cell and the macros header.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_ready   | pixel_col, pixel_row, current_alpha
//   rsp     | out       | rsp_valid / rsp_ready   | new_alpha, inside_brush
//   csr     | in        | csr_valid / csr_ready   | index, data (csr_ready tied high)
//
// One pixel per cycle while rsp_ready is high or a stage is empty. The pipeline depth
// is COORD-independent, set by one square-root cell per root bit and one
// divider cell per strength bit. Each stage advances when it or any later stage is
// empty or the response is taken, so bubbles close up under rsp stalls.
// Reset clears the stage valid bits and sets the configuration registers to their defaults.
`include "soft_circular_alpha_brush_top_macros.svh"

module soft_circular_alpha_brush_top #(
   parameter int COORD_BITS     = scab_pkg::COORD_BITS_DEF,
   parameter int DIST_FRAC_BITS = scab_pkg::DIST_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [COORD_BITS-1:0]               req_pixel_col,
   input  logic [COORD_BITS-1:0]               req_pixel_row,
   input  logic [scab_pkg::ALPHA_BITS-1:0]     req_current_alpha,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [scab_pkg::ALPHA_BITS-1:0]     rsp_new_alpha,
   output logic                                rsp_inside_brush,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [scab_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [((COORD_BITS + 2 > scab_pkg::RAD_BITS) ? COORD_BITS + 2
                  : scab_pkg::RAD_BITS)-1:0]   csr_data
);
   import scab_pkg::*;

   localparam int CB   = COORD_BITS + 2;
   localparam int DXB  = COORD_BITS + 3;
   localparam int MB   = COORD_BITS + 2;
   localparam int SQB  = 2 * MB;
   localparam int SB   = SQB + 1;
   localparam int CMPW = (SB > 2 * RAD_BITS) ? SB : 2 * RAD_BITS;
   localparam int RB   = RAD_BITS + DIST_FRAC_BITS;
   localparam int AB   = 2 * RB;
   localparam int RW   = RB + 2;
   localparam int NB   = RB + STR_FRAC_BITS;
   localparam int QB   = STR_FRAC_BITS;
   localparam int HPB  = RAD_BITS + HARD_BITS;
   localparam int PB   = ALPHA_BITS + 1 + STR_BITS + 1;
   localparam int MAGB = PB - STR_FRAC_BITS;
   localparam int RESB = MAGB + 2;

   localparam int S_IN    = 0;
   localparam int S_ABS   = 1;
   localparam int S_SQ    = 2;
   localparam int S_SUM   = 3;
   localparam int S_ROOT0 = 4;
   localparam int S_SETUP = S_ROOT0 + RB;
   localparam int S_DIV0  = S_SETUP + 1;
   localparam int S_MUL   = S_DIV0 + QB;
   localparam int S_OUT   = S_MUL + 1;
   localparam int NST     = S_OUT + 1;

   // ---------------- configuration registers ----------------
   logic [CB-1:0]         center_col_ff;
   logic [CB-1:0]         center_row_ff;
   logic [RAD_BITS-1:0]   radius_ff;
   logic [ALPHA_BITS-1:0] target_ff;
   logic [HARD_BITS-1:0]  hardness_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= '0;
         center_row_ff <= '0;
         radius_ff     <= RAD_BITS'(1);
         target_ff     <= ALPHA_MAX;
         hardness_ff   <= STR_ONE;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CENTER_COL:   center_col_ff <= csr_data[CB-1:0];
            CSR_CENTER_ROW:   center_row_ff <= csr_data[CB-1:0];
            CSR_BRUSH_RADIUS: radius_ff     <= csr_data[RAD_BITS-1:0];
            CSR_TARGET_ALPHA: target_ff     <= csr_data[ALPHA_BITS-1:0];
            CSR_HARDNESS_Q8:  hardness_ff   <= csr_data[HARD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Values derived from the registers; rad_sq, hard_s and feather are registered
   logic [HARD_BITS-1:0]  hsat;
   logic [HPB-1:0]        hprod;
   logic [2*RAD_BITS-1:0] rad_sq_ff, rad_sq_in;
   logic [NB-1:0]         hard_s_ff, hard_s_in;
   logic [NB-1:0]         feather_ff, feather_in;
   logic [RB-1:0]         rad_fix;
   logic [NB-1:0]         rad_s;

   always_comb begin
      hsat       = (hardness_ff > STR_ONE) ? STR_ONE : hardness_ff;
      hprod      = HPB'(radius_ff) * HPB'(hsat);
      hard_s_in  = NB'({hprod, {DIST_FRAC_BITS{1'b0}}});
      rad_sq_in  = (2 * RAD_BITS)'(radius_ff) * (2 * RAD_BITS)'(radius_ff);
      rad_fix    = {radius_ff, {DIST_FRAC_BITS{1'b0}}};
      rad_s      = {rad_fix, {STR_FRAC_BITS{1'b0}}};
      feather_in = rad_s - hard_s_ff;
   end

   always_ff @(posedge clock) begin
      rad_sq_ff  <= rad_sq_in;
      hard_s_ff  <= hard_s_in;
      feather_ff <= feather_in;
   end

   // ---------------- stage handshake ----------------
   logic [NST-1:0] vld_ff, vld_in;
   logic [NST-1:0] rdy;

   genvar gi;
   generate
      for (gi = 0; gi < NST; gi++) begin : g_rdy
         // advance when this or any later stage is empty or the response leaves
         assign rdy[gi] = rsp_ready | ~(&vld_ff[NST-1:gi]);
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < NST; i++) begin
         if (rdy[i]) begin
            vld_in[i] = (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = rdy[S_IN];
   assign rsp_valid = vld_ff[S_OUT];

   // ---------------- input register ----------------
   logic [COORD_BITS-1:0] in_col_ff, in_row_ff;
   logic [ALPHA_BITS-1:0] in_cur_ff;

   always_ff @(posedge clock) begin
      if (rdy[S_IN]) begin
         in_col_ff <= req_pixel_col;
         in_row_ff <= req_pixel_row;
         in_cur_ff <= req_current_alpha;
      end
   end

   // ---------------- offset magnitudes ----------------
   logic signed [DXB-1:0] dx, dy;
   logic [MB-1:0]         adx_ff, adx_in, ady_ff, ady_in;
   pass_type              abs_pass_ff, abs_pass_in;

   always_comb begin
      dx = $signed({3'b000, in_col_ff}) - $signed({center_col_ff[CB-1], center_col_ff});
      dy = $signed({3'b000, in_row_ff}) - $signed({center_row_ff[CB-1], center_row_ff});
      adx_in = dx[DXB-1] ? MB'(-dx) : MB'(dx);
      ady_in = dy[DXB-1] ? MB'(-dy) : MB'(dy);
      abs_pass_in.cur  = in_cur_ff;
      abs_pass_in.hit  = 1'b0;
      abs_pass_in.full = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rdy[S_ABS]) begin
         adx_ff      <= adx_in;
         ady_ff      <= ady_in;
         abs_pass_ff <= abs_pass_in;
      end
   end

   // ---------------- squares ----------------
   logic [SQB-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   pass_type       sq_pass_ff;

   assign sqx_in = SQB'(adx_ff) * SQB'(adx_ff);
   assign sqy_in = SQB'(ady_ff) * SQB'(ady_ff);

   always_ff @(posedge clock) begin
      if (rdy[S_SQ]) begin
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
         sq_pass_ff <= abs_pass_ff;
      end
   end

   // ---------------- sum and radius test ----------------
   logic [CMPW-1:0] sumsq;
   logic [AB-1:0]   arg_ff, arg_in;
   pass_type        sum_pass_ff, sum_pass_in;

   always_comb begin
      sumsq           = CMPW'(sqx_ff) + CMPW'(sqy_ff);
      sum_pass_in     = sq_pass_ff;
      sum_pass_in.hit = (sumsq <= CMPW'(rad_sq_ff));
      // outside pixels never use the root, so drop the high bits
      arg_in          = {sumsq[2*RAD_BITS-1:0], {(2 * DIST_FRAC_BITS){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (rdy[S_SUM]) begin
         arg_ff      <= arg_in;
         sum_pass_ff <= sum_pass_in;
      end
   end

   // ---------------- square-root chain ----------------
   logic [RW-1:0] sq_rem  [0:RB];
   logic [RB-1:0] sq_root [0:RB];
   logic [AB-1:0] sq_arg  [0:RB];
   pass_type      sq_pass [0:RB];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_arg[0]  = arg_ff;
   assign sq_pass[0] = sum_pass_ff;

   generate
      for (gi = 0; gi < RB; gi++) begin : g_root
         scab_sqrt_cell #(
            .ROOT_BITS (RB)
         ) u_cell (
            .clock   (clock),
            .advance (rdy[S_ROOT0 + gi]),
            .up_rem  (sq_rem[gi]),
            .up_root (sq_root[gi]),
            .up_arg  (sq_arg[gi]),
            .up_pass (sq_pass[gi]),
            .dn_rem  (sq_rem[gi + 1]),
            .dn_root (sq_root[gi + 1]),
            .dn_arg  (sq_arg[gi + 1]),
            .dn_pass (sq_pass[gi + 1])
         );
      end
   endgenerate

   // ---------------- falloff setup ----------------
   logic [NB-1:0] dist_s;
   logic [NB-1:0] num_ff, num_in;
   pass_type      set_pass_ff, set_pass_in;

   always_comb begin
      dist_s           = {sq_root[RB], {STR_FRAC_BITS{1'b0}}};
      set_pass_in      = sq_pass[RB];
      set_pass_in.full = (feather_ff == '0) || (dist_s <= hard_s_ff);
      num_in           = (rad_s > dist_s) ? rad_s - dist_s : '0;
   end

   always_ff @(posedge clock) begin
      if (rdy[S_SETUP]) begin
         num_ff      <= num_in;
         set_pass_ff <= set_pass_in;
      end
   end

   // ---------------- division chain ----------------
   logic [NB-1:0] dv_rem  [0:QB];
   logic [QB-1:0] dv_quo  [0:QB];
   pass_type      dv_pass [0:QB];

   assign dv_rem[0]  = num_ff;
   assign dv_quo[0]  = '0;
   assign dv_pass[0] = set_pass_ff;

   generate
      for (gi = 0; gi < QB; gi++) begin : g_div
         scab_div_cell #(
            .NUM_BITS (NB)
         ) u_cell (
            .clock   (clock),
            .advance (rdy[S_DIV0 + gi]),
            .divisor (feather_ff),
            .up_rem  (dv_rem[gi]),
            .up_quo  (dv_quo[gi]),
            .up_pass (dv_pass[gi]),
            .dn_rem  (dv_rem[gi + 1]),
            .dn_quo  (dv_quo[gi + 1]),
            .dn_pass (dv_pass[gi + 1])
         );
      end
   endgenerate

   // ---------------- blend product ----------------
   logic [STR_BITS-1:0]          strength;
   logic signed [ALPHA_BITS:0]   delta;
   logic signed [PB-1:0]         prod_ff, prod_in;
   pass_type                     mul_pass_ff;

   always_comb begin
      strength = dv_pass[QB].full ? STR_ONE : {1'b0, dv_quo[QB]};
      delta    = $signed({1'b0, target_ff}) - $signed({1'b0, dv_pass[QB].cur});
      prod_in  = delta * $signed({1'b0, strength});
   end

   always_ff @(posedge clock) begin
      if (rdy[S_MUL]) begin
         prod_ff     <= prod_in;
         mul_pass_ff <= dv_pass[QB];
      end
   end

   // ---------------- round, clamp, output register ----------------
   logic [PB-1:0]            abs_p;
   logic [PB-1:0]            rnd;
   logic [MAGB-1:0]          mag;
   logic signed [RESB-1:0]   cur_s, mag_s, res;
   logic [ALPHA_BITS-1:0]    alpha_ff, alpha_in;
   logic                     hit_ff;

   always_comb begin
      abs_p = prod_ff[PB-1] ? PB'(-prod_ff) : PB'(prod_ff);
      rnd   = abs_p + PB'(HALF_LSB);
      mag   = rnd[PB-1:STR_FRAC_BITS];
      cur_s = $signed(RESB'(mul_pass_ff.cur));
      mag_s = $signed(RESB'(mag));
      res   = prod_ff[PB-1] ? cur_s - mag_s : cur_s + mag_s;
      if (!mul_pass_ff.hit) begin
         alpha_in = mul_pass_ff.cur;
      end else if (res < 0) begin
         alpha_in = '0;
      end else if (res > $signed(RESB'(ALPHA_MAX))) begin
         alpha_in = ALPHA_MAX;
      end else begin
         alpha_in = res[ALPHA_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[S_OUT]) begin
         alpha_ff <= alpha_in;
         hit_ff   <= mul_pass_ff.hit;
      end
   end

   assign rsp_new_alpha    = alpha_ff;
   assign rsp_inside_brush = hit_ff;

   // ---------------- assertions ----------------
   `SCAB_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_ready, (&vld_ff) && !rsp_ready, "request stalled while a stage is free")
   `SCAB_ASSERT_NOW(a_root_within_radius, clock, reset, vld_ff[S_SETUP-1] && sq_pass[RB].hit, sq_root[RB] <= rad_fix, "distance beyond radius for a pixel inside the brush")
   `SCAB_ASSERT_NEXT(a_outside_passes, clock, reset, vld_ff[S_MUL] && !mul_pass_ff.hit && rdy[S_OUT], (rsp_new_alpha == $past(mul_pass_ff.cur)) && !rsp_inside_brush, "pixel outside the brush changed")

endmodule
